// ===== hw/rtl/uwsp_pkg.sv =====
// Shared types and constants of the unit-weight shortest path block.
`default_nettype none

package uwsp_pkg;

    // Field widths of the request and result channels
    localparam int ACTION_W = 2;
    localparam int VERTEX_W = 4;
    localparam int HOPS_W   = 4;
    localparam int VCOUNT_W = 5;

    // Vertices that a 4-bit field can name
    localparam int ADDR_SPAN = 2 ** VERTEX_W;

    localparam int MAX_VERTICES_DEF = 16;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

    // Distance scratch: 5 bits, all-ones means not reached
    localparam int DIST_W = 5;
    localparam logic [DIST_W-1:0] DIST_UNREACHED = 5'd31;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_EDGE = 2'd0,
        ACT_CLR_EDGE = 2'd1,
        ACT_QUERY    = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

endpackage

`default_nettype wire

// ===== hw/rtl/uwsp_if.sv =====
// Request and result channel interfaces of the shortest path block.
`default_nettype none

interface uwsp_req_if;
    import uwsp_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;

    modport source (output valid, output action, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input action, input vertex_a, input vertex_b,
                    output ready);
endinterface

interface uwsp_res_if;
    import uwsp_pkg::*;

    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] path_vertex;
    logic [HOPS_W-1:0]   hop_distance;
    logic                found;
    logic                last;

    modport source (output valid, output path_vertex, output hop_distance,
                    output found, output last, input ready);
    modport sink   (input valid, input path_vertex, input hop_distance,
                    input found, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/unit_weight_shortest_path_top.sv =====
// Top level: adjacency store and sequential unit-weight Dijkstra search.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------
//  i_req     | in  | valid / ready | action, vertex_a, vertex_b
//  o_res     | out | valid / ready | path_vertex, hop_distance, found, last
//  i_cfg_*   | in  | write enable  | vertex_count (5 bits)
//
//  Sequence: an edge request is written as it is accepted. A query with m =
//  min(vertex_count, used rows) vertices in play searches one vertex per cycle
//  through the single compare unit, a pick scan and a relax scan per round,
//  one round per vertex reached, then a closing pick scan; then comes a path
//  walk, and hops+1 results are emitted, entry first.
//  Reset clears the adjacency rows and sets vertex_count to 16.
//  Results sit in an output register; a stalled sink holds the emit step,
//  and i_req is not ready until the query's last result is loaded.
`default_nettype none

module unit_weight_shortest_path_top #(
    parameter int MAX_VERTICES = uwsp_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [uwsp_pkg::VCOUNT_W-1:0] i_cfg_wdata,
    uwsp_req_if.sink                           i_req,
    uwsp_res_if.source                         o_res
);
    import uwsp_pkg::*;

    // Only vertices a 4-bit field can name ever carry edges
    localparam int ROWS = (MAX_VERTICES < ADDR_SPAN) ? MAX_VERTICES : ADDR_SPAN;
    localparam int VW   = $clog2(ROWS);
    localparam int MW   = $clog2(ROWS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PICK  = 6'b000010,
        S_RELAX = 6'b000100,
        S_WALK  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_MISS  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [VCOUNT_W-1:0]   r_vcount;

    // Graph and per-query scratch
    logic [ROWS-1:0]       r_adj  [ROWS];
    logic [DIST_W-1:0]     r_dist [ROWS];
    logic [ROWS-1:0]       r_done;
    logic [VW-1:0]         r_pred [ROWS];
    logic [VW-1:0]         r_path [ROWS];

    // Sequencer
    logic [VW-1:0]         r_exit, n_exit;
    logic [VW-1:0]         r_j, n_j;
    logic [DIST_W-1:0]     r_least, n_least;
    logic [VW-1:0]         r_pick, n_pick;
    logic                  r_have, n_have;
    logic [VW-1:0]         r_hops, n_hops;
    logic [VW-1:0]         r_k, n_k;
    logic [VW-1:0]         r_cur, n_cur;

    // Output register
    logic                  r_ov, n_ov;
    logic [VERTEX_W-1:0]   r_o_vertex, n_o_vertex;
    logic [HOPS_W-1:0]     r_o_hops, n_o_hops;
    logic                  r_o_found, n_o_found;
    logic                  r_o_last, n_o_last;

    // Array write strobes
    logic                  w_init, w_set_done, w_relax_wr, w_path_wr;
    logic                  w_edge_set, w_edge_clr;

    logic                  w_take;
    logic                  w_slot;
    logic [MW-1:0]         w_span;
    logic                  w_scan_end;
    logic                  w_edge_ok;
    logic                  w_query_ok;
    logic [VW-1:0]         w_a_idx, w_b_idx;
    logic [DIST_W-1:0]     w_dj;
    logic [DIST_W-1:0]     w_least1;
    logic [DIST_W-1:0]     w_dexit;

    // Vertices in play this query
    assign w_span = (r_vcount < VCOUNT_W'(ROWS)) ? r_vcount[MW-1:0] : MW'(ROWS);
    assign w_scan_end = ((MW'(r_j) + MW'(1)) == w_span);

    assign w_a_idx = i_req.vertex_a[VW-1:0];
    assign w_b_idx = i_req.vertex_b[VW-1:0];

    assign w_edge_ok = ({1'b0, i_req.vertex_a} < (VERTEX_W + 1)'(ROWS))
                     && ({1'b0, i_req.vertex_b} < (VERTEX_W + 1)'(ROWS))
                     && (i_req.vertex_a != i_req.vertex_b);
    assign w_query_ok = ({1'b0, i_req.vertex_a} < (VERTEX_W + 1)'(w_span))
                      && ({1'b0, i_req.vertex_b} < (VERTEX_W + 1)'(w_span));

    assign w_dj     = r_dist[r_j];
    assign w_least1 = r_least + DIST_W'(1);
    assign w_dexit  = r_dist[r_exit];

    assign i_req.ready = (r_state == S_IDLE);
    assign w_take      = i_req.valid && (r_state == S_IDLE);
    assign w_slot      = !r_ov || o_res.ready;

    assign o_res.valid        = r_ov;
    assign o_res.path_vertex  = r_o_vertex;
    assign o_res.hop_distance = r_o_hops;
    assign o_res.found        = r_o_found;
    assign o_res.last         = r_o_last;

    always_comb begin
        n_state    = r_state;
        n_exit     = r_exit;
        n_j        = r_j;
        n_least    = r_least;
        n_pick     = r_pick;
        n_have     = r_have;
        n_hops     = r_hops;
        n_k        = r_k;
        n_cur      = r_cur;
        n_ov       = r_ov && !o_res.ready;
        n_o_vertex = r_o_vertex;
        n_o_hops   = r_o_hops;
        n_o_found  = r_o_found;
        n_o_last   = r_o_last;
        w_init     = 1'b0;
        w_set_done = 1'b0;
        w_relax_wr = 1'b0;
        w_path_wr  = 1'b0;
        w_edge_set = 1'b0;
        w_edge_clr = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    case (t_action'(i_req.action))
                        ACT_SET_EDGE: w_edge_set = w_edge_ok;
                        ACT_CLR_EDGE: w_edge_clr = w_edge_ok;
                        ACT_QUERY: begin
                            if (w_query_ok) begin
                                w_init  = 1'b1;
                                n_exit  = w_b_idx;
                                n_j     = '0;
                                n_least = DIST_UNREACHED;
                                n_have  = 1'b0;
                                n_state = S_PICK;
                            end else begin
                                n_state = S_MISS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PICK: begin
                // least distance among open vertices, lowest index on ties
                if (!r_done[r_j] && (w_dj < r_least)) begin
                    n_least = w_dj;
                    n_pick  = r_j;
                    n_have  = 1'b1;
                end
                if (w_scan_end) begin
                    n_j = '0;
                    if (n_have) begin
                        w_set_done = 1'b1;
                        n_state    = S_RELAX;
                    end else if (w_dexit == DIST_UNREACHED) begin
                        n_state = S_MISS;
                    end else begin
                        n_hops  = w_dexit[VW-1:0];
                        n_k     = w_dexit[VW-1:0];
                        n_cur   = r_exit;
                        n_state = S_WALK;
                    end
                end else begin
                    n_j = r_j + VW'(1);
                end
            end
            S_RELAX: begin
                w_relax_wr = !r_done[r_j] && r_adj[r_pick][r_j] && (w_dj > w_least1);
                if (w_scan_end) begin
                    n_j     = '0;
                    n_least = DIST_UNREACHED;
                    n_have  = 1'b0;
                    n_state = S_PICK;
                end else begin
                    n_j = r_j + VW'(1);
                end
            end
            S_WALK: begin
                // exit back to entry, stored so the entry comes out first
                w_path_wr = 1'b1;
                n_cur     = r_pred[r_cur];
                if (r_k == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k - VW'(1);
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_ov       = 1'b1;
                    n_o_vertex = VERTEX_W'(r_path[r_k]);
                    n_o_hops   = HOPS_W'(r_hops);
                    n_o_found  = 1'b1;
                    n_o_last   = (r_k == r_hops);
                    if (r_k == r_hops) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + VW'(1);
                    end
                end
            end
            S_MISS: begin
                if (w_slot) begin
                    n_ov       = 1'b1;
                    n_o_vertex = '0;
                    n_o_hops   = '0;
                    n_o_found  = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_vcount <= VCOUNT_RST;
            for (int r = 0; r < ROWS; r++) begin
                r_adj[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (w_edge_set) begin
                r_adj[w_a_idx][w_b_idx] <= 1'b1;
                r_adj[w_b_idx][w_a_idx] <= 1'b1;
            end
            if (w_edge_clr) begin
                r_adj[w_a_idx][w_b_idx] <= 1'b0;
                r_adj[w_b_idx][w_a_idx] <= 1'b0;
            end
        end
    end

    // Payload and scratch, no reset
    always_ff @(posedge i_clk) begin
        r_exit     <= n_exit;
        r_j        <= n_j;
        r_least    <= n_least;
        r_pick     <= n_pick;
        r_have     <= n_have;
        r_hops     <= n_hops;
        r_k        <= n_k;
        r_cur      <= n_cur;
        r_o_vertex <= n_o_vertex;
        r_o_hops   <= n_o_hops;
        r_o_found  <= n_o_found;
        r_o_last   <= n_o_last;

        if (w_init) begin
            r_done <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_dist[r] <= (VW'(r) == w_a_idx) ? '0 : DIST_UNREACHED;
            end
        end
        if (w_set_done) begin
            r_done[n_pick] <= 1'b1;
        end
        if (w_relax_wr) begin
            r_dist[r_j] <= w_least1;
            r_pred[r_j] <= r_pick;
        end
        if (w_path_wr) begin
            r_path[r_k] <= r_cur;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_unit_weight_shortest_path_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the unit-weight shortest path block: directed and random requests.
module tb_unit_weight_shortest_path_top;
    import uwsp_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int NUM_V         = MAX_VERTICES_DEF;
    localparam int NOT_REACHED   = 255;        // distance code of the predictor
    localparam int SETTLE_CYCLES = 16;         // edge requests are applied as they are accepted
    localparam int RUN_LIMIT_NS  = 20_000_000; // limit on the run time, several times the slowest run

    typedef logic [VERTEX_W-1:0] t_vertex;

    // One result of a query, as the block should present it
    typedef struct packed {
        t_vertex             path_vertex;
        logic [HOPS_W-1:0]   hop_distance;
        logic                found;
        logic                last;
    } t_path_step;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [VCOUNT_W-1:0] i_cfg_wdata;

    uwsp_req_if req_bus ();
    uwsp_res_if res_bus ();

    unit_weight_shortest_path_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_res       (res_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the block: adjacency rows and the vertex count register
    logic [NUM_V-1:0]    adj_rows [NUM_V];
    logic [VCOUNT_W-1:0] vertex_count_q;

    // Path steps still owed by the block, oldest first
    t_path_step  awaited_steps [$];
    int unsigned mismatch_count = 0;
    bit          idle_on;

    // ------------------------------------------------------------------
    // Path prediction
    // ------------------------------------------------------------------
    function automatic void push_step(t_vertex v, int unsigned hops, bit fnd, bit lst);
        t_path_step s;
        s.path_vertex  = v;
        s.hop_distance = hops;
        s.found        = fnd;
        s.last         = lst;
        awaited_steps.push_back(s);
    endfunction

    // Array Dijkstra with unit weights. Lowest-numbered vertex wins a tie in
    // the pick, and only a strictly shorter distance replaces the old one,
    // so the first vertex to reach a neighbour stays its predecessor.
    function automatic void predict_query(t_vertex src, t_vertex dst);
        int unsigned n;
        int unsigned best_dist [NUM_V];
        bit          done [NUM_V];
        t_vertex     pred [NUM_V];
        t_vertex     route [NUM_V];
        int unsigned pick;
        int unsigned least;
        int unsigned hops;
        t_vertex     cur;
        n = (vertex_count_q > NUM_V) ? NUM_V : vertex_count_q;
        // entry or exit out of use, vertex count zero among them
        if (src >= n || dst >= n) begin
            push_step('0, 0, 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            best_dist[i] = NOT_REACHED;
            done[i]      = 1'b0;
            pred[i]      = src;
        end
        best_dist[src] = 0;
        for (int r = 0; r < n; r++) begin
            pick  = n;
            least = NOT_REACHED;
            for (int j = 0; j < n; j++) begin
                if (!done[j] && best_dist[j] < least) begin
                    least = best_dist[j];
                    pick  = j;
                end
            end
            if (pick >= n)
                break;          // only unreached vertices left
            done[pick] = 1'b1;
            for (int j = 0; j < n; j++) begin
                if (!done[j] && adj_rows[pick][j] && best_dist[j] > least + 1) begin
                    best_dist[j] = least + 1;
                    pred[j]      = pick;
                end
            end
        end
        if (best_dist[dst] == NOT_REACHED) begin
            push_step('0, 0, 1'b0, 1'b1);
            return;
        end
        // walk back from the exit, then emit entry first
        hops = best_dist[dst];
        cur  = dst;
        for (int k = hops; k >= 0; k--) begin
            route[k] = cur;
            cur      = pred[cur];
        end
        for (int k = 0; k <= hops; k++)
            push_step(route[k], hops, 1'b1, k == hops);
    endfunction

    function automatic void apply_request(t_action act, t_vertex a, t_vertex b);
        case (act)
            ACT_SET_EDGE, ACT_CLR_EDGE: begin
                // self-loops leave the matrix alone
                if (a != b) begin
                    adj_rows[a][b] = (act == ACT_SET_EDGE);
                    adj_rows[b][a] = (act == ACT_SET_EDGE);
                end
            end
            ACT_QUERY: predict_query(a, b);
            default: ;      // unused action: ignored
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Valid is left high after acceptance so back-to-back requests need no
    // second assignment in one step; anything that pauses lowers it first.
    task automatic send_request(t_action act, t_vertex a, t_vertex b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.action   <= act;
        req_bus.vertex_a <= a;
        req_bus.vertex_b <= b;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        apply_request(act, a, b);
    endtask

    // Hold the request channel until every owed path step has arrived
    task automatic await_all_results();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_steps.size() != 0);
    endtask

    task automatic drain_block();
        await_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only ever happen with the block idle
    task automatic write_vertex_count(logic [VCOUNT_W-1:0] value);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        vertex_count_q  = value;
    endtask

    task automatic clear_graph();
        for (int i = 0; i < NUM_V; i++)
            for (int j = i + 1; j < NUM_V; j++)
                if (adj_rows[i][j])
                    send_request(ACT_CLR_EDGE, i, j);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Runs at the reset vertex count of 16
    task automatic test_special_cases();
        send_request(ACT_QUERY, 0, 0);          // entry equals exit, empty graph
        send_request(ACT_QUERY, 0, 15);         // unreachable exit
        send_request(ACT_SET_EDGE, 0, 1);
        send_request(ACT_SET_EDGE, 15, 1);
        send_request(ACT_SET_EDGE, 0, 2);
        send_request(ACT_SET_EDGE, 2, 15);
        send_request(ACT_QUERY, 0, 15);         // tie: through 1, the lower vertex
        send_request(ACT_SET_EDGE, 3, 3);       // self-loop
        send_request(ACT_QUERY, 3, 3);
        send_request(ACT_QUERY, 3, 4);
        send_request(ACT_CLR_EDGE, 1, 15);
        send_request(ACT_QUERY, 15, 0);         // now through 2
        send_request(ACT_UNUSED, 15, 15);
        send_request(ACT_CLR_EDGE, 14, 13);     // edge that was never set
        send_request(ACT_QUERY, 1, 2);
    endtask

    task automatic test_vertex_count();
        write_vertex_count(3);
        send_request(ACT_QUERY, 0, 2);
        send_request(ACT_QUERY, 0, 3);          // exit out of use
        send_request(ACT_QUERY, 15, 0);         // entry out of use
        send_request(ACT_SET_EDGE, 10, 11);     // kept while out of use
        write_vertex_count(0);
        send_request(ACT_QUERY, 0, 0);
        write_vertex_count(1);
        send_request(ACT_QUERY, 0, 0);
        send_request(ACT_QUERY, 0, 1);
        write_vertex_count(31);                 // above the vertex limit
        send_request(ACT_QUERY, 10, 11);
        send_request(ACT_QUERY, 11, 2);
    endtask

    // A shuffled chain over all vertices gives the longest paths, then a
    // shortcut halves one of them.
    task automatic test_long_paths();
        t_vertex     order [NUM_V];
        t_vertex     tmp;
        int unsigned k;
        write_vertex_count(NUM_V);
        clear_graph();
        for (int i = 0; i < NUM_V; i++)
            order[i] = i;
        for (int i = NUM_V - 1; i > 0; i--) begin
            k        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        for (int i = 0; i < NUM_V - 1; i++)
            send_request(ACT_SET_EDGE, order[i], order[i + 1]);
        send_request(ACT_QUERY, order[0], order[NUM_V - 1]);
        send_request(ACT_QUERY, order[NUM_V - 1], order[0]);
        send_request(ACT_QUERY, order[3], order[12]);
        send_request(ACT_SET_EDGE, order[0], order[8]);
        send_request(ACT_QUERY, order[0], order[NUM_V - 1]);
    endtask

    // Phases of random graph building and queries, each at its own vertex
    // count. Most requests stay within the vertices in use; the rest are
    // full-range noise, self-loops and unused actions.
    task automatic test_random_graphs(int unsigned items);
        int unsigned         counted;
        int unsigned         phase;
        int unsigned         n;
        int unsigned         roll;
        logic [VCOUNT_W-1:0] vc;
        t_vertex             a;
        t_vertex             b;
        t_action             act;
        bit                  hold_each_query;
        counted = 0;
        phase   = 0;
        while (counted < items) begin
            case (phase % 6)
                0: vc = $urandom_range(2, 6);
                1: vc = NUM_V;
                2: vc = $urandom_range(4, 10);
                3: vc = $urandom_range(17, 31);
                4: vc = $urandom_range(1, 3);
                default: vc = $urandom_range(0, 15);
            endcase
            write_vertex_count(vc);
            n = (vc > NUM_V) ? NUM_V : vc;
            if ($urandom_range(0, 2) == 0)
                clear_graph();
            // one phase waits out every query before the next request
            hold_each_query = (phase == 2);
            repeat (30) begin
                roll = $urandom_range(0, 99);
                a    = $urandom_range(0, NUM_V - 1);
                b    = $urandom_range(0, NUM_V - 1);
                if (n >= 1 && roll < 88) begin
                    a = $urandom_range(0, n - 1);
                    b = $urandom_range(0, n - 1);
                    if (roll < 60 && a == b && n >= 2)
                        b = (a + 1) % n;
                end
                if (roll < 45)
                    act = ACT_SET_EDGE;
                else if (roll < 60)
                    act = ACT_CLR_EDGE;
                else if (roll < 88)
                    act = ACT_QUERY;
                else if (roll < 93)
                    act = $urandom_range(0, 1) ? ACT_SET_EDGE : ACT_CLR_EDGE;
                else if (roll < 97)
                    act = ACT_QUERY;
                else
                    act = ACT_UNUSED;
                send_request(act, a, b);
                counted++;
                if (hold_each_query && act == ACT_QUERY)
                    await_all_results();
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    // Ready idles in bursts while idle_on is set, otherwise stays high
    initial begin : result_sink
        res_bus.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_path_step want;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (awaited_steps.size() == 0) begin
                $error("result with none owed: path_vertex %0d hop_distance %0d",
                       res_bus.path_vertex, res_bus.hop_distance);
                mismatch_count++;
            end else begin
                want = awaited_steps.pop_front();
                if (res_bus.path_vertex !== want.path_vertex) begin
                    $error("path_vertex: expected %0d, got %0d",
                           want.path_vertex, res_bus.path_vertex);
                    mismatch_count++;
                end
                if (res_bus.hop_distance !== want.hop_distance) begin
                    $error("hop_distance: expected %0d, got %0d",
                           want.hop_distance, res_bus.hop_distance);
                    mismatch_count++;
                end
                if (res_bus.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, res_bus.found);
                    mismatch_count++;
                end
                if (res_bus.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_bus.last);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.action   <= ACT_SET_EDGE;
        req_bus.vertex_a <= '0;
        req_bus.vertex_b <= '0;
        idle_on        = 1'b1;
        vertex_count_q = VCOUNT_RST;
        for (int i = 0; i < NUM_V; i++)
            adj_rows[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_vertex_count();
        test_long_paths();
        test_random_graphs(150);
        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        test_random_graphs(30);

        drain_block();
        if (mismatch_count == 0)
            $display("[unit_weight_shortest_path_top] OK");
        else
            $display("[unit_weight_shortest_path_top] ERROR");
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("[unit_weight_shortest_path_top] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/uwsp_pkg.sv
hw/rtl/uwsp_if.sv
hw/rtl/unit_weight_shortest_path_top.sv
test/tb_unit_weight_shortest_path_top.sv
